@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the timer manager RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property that must hold at every clock edge outside reset.
`define STEM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("stem assertion failed");
// Condition that must never be true outside reset.
`define STEM_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("stem forbidden condition seen");
`endif

@@ hw/rtl/stem_pkg.sv @@
// Types, codes and constants of the software timer expiry manager.
package stem_pkg;
   localparam int NUM_SLOTS_DEF = 16;
   localparam int TIME_BITS_DEF = 32;
   localparam int MAX_RESULTS = 16;
   localparam logic [30:0] MAX_WAIT_RESET = 31'(1000 * 60);
   localparam int QUEUE_DEPTH = 2;
   localparam int QW = $clog2(QUEUE_DEPTH);

   localparam logic [2:0] OP_START = 3'd0;
   localparam logic [2:0] OP_STOP = 3'd1;
   localparam logic [2:0] OP_RESTART = 3'd2;
   localparam logic [2:0] OP_CHECK = 3'd3;
   localparam logic [2:0] OP_QUERY = 3'd4;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_BUSY = 2'd1;
   localparam logic [1:0] STATUS_EARLIEST = 2'd2;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [3:0]  slot_id;
      logic [30:0] period;
      logic        auto_reload;
      logic        reload_from_now;
      logic [31:0] now_time;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        expired_valid;
      logic [3:0]  expired_slot;
      logic [30:0] remaining;
      logic        last;
   } rsp_type;

   typedef enum logic [2:0] {
      CLS_START,
      CLS_RESTART,
      CLS_STOP,
      CLS_CHECK,
      CLS_QUERY,
      CLS_NOP
   } cls_type;

   typedef struct packed {
      cls_type cls;
      logic    slot_ok;
      req_type req;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE,
      ST_FLUSH
   } st_type;
endpackage

@@ hw/rtl/stem_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module stem_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

@@ hw/rtl/stem_front.sv @@
// Front end: accepts commands, classifies them and queues them for the back end.
module stem_front import stem_pkg::*; #(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   input  req_type   req_item,
   output logic      busy,
   input  logic      pop,
   output queue_type q_out
);
   localparam int SW = $clog2(NUM_SLOTS);
   localparam int IW = (SW > 4) ? SW : 4;

   cmd_type        cmd;
   cmd_type        fifo_ff [QUEUE_DEPTH];
   logic [QW-1:0]  head_ff, head_in, tail_ff, tail_in;
   logic [QW:0]    cnt_ff, cnt_in;
   logic           push, pull;

   always_comb begin
      cmd.req = req_item;
      cmd.slot_ok = (IW + 1)'(req_item.slot_id) < (IW + 1)'(NUM_SLOTS);
      case (req_item.opcode)
         OP_START:   cmd.cls = CLS_START;
         OP_STOP:    cmd.cls = CLS_STOP;
         OP_RESTART: cmd.cls = CLS_RESTART;
         OP_CHECK:   cmd.cls = CLS_CHECK;
         OP_QUERY:   cmd.cls = CLS_QUERY;
         default:    cmd.cls = CLS_NOP;
      endcase
   end

   assign busy = (cnt_ff == (QW + 1)'(QUEUE_DEPTH));
   assign push = start && !busy;
   assign pull = pop && (cnt_ff != '0);
   assign q_out.valid = (cnt_ff != '0);
   assign q_out.cmd = fifo_ff[head_ff];

   always_comb begin
      head_in = pull ? head_ff + QW'(1) : head_ff;
      tail_in = push ? tail_ff + QW'(1) : tail_ff;
      cnt_in = cnt_ff + (QW + 1)'(push) - (QW + 1)'(pull);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         cnt_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[tail_ff] <= cmd;
      end
   end
endmodule

@@ hw/rtl/stem_back.sv @@
// Back end: executes queued commands by scanning the slot table one slot a cycle.
module stem_back import stem_pkg::*; #(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF,
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  queue_type   q_in,
   output logic        pop,
   input  logic [30:0] max_wait,
   output logic        rsp_valid,
   output rsp_type     rsp_item
);
   localparam int SW = $clog2(NUM_SLOTS);
   localparam int TB = TIME_BITS;
   localparam int EW = 2 * TB + 2;
   localparam int CW = (TB > 31) ? TB : 31;
   localparam int NW = $clog2(MAX_RESULTS + 1);
   localparam logic [TB-1:0] TSIGN = {1'b1, {(TB - 1){1'b0}}};
   localparam logic [SW-1:0] LAST_IDX = SW'(NUM_SLOTS - 1);

   st_type                state_ff, state_in;
   cmd_type               cmd_ff, cmd_in;
   logic [SW-1:0]         idx_ff, idx_in, cmp_idx_ff, cmp_idx_in;
   logic                  cmp_vld_ff, cmp_vld_in;
   logic                  best_found_ff, best_found_in;
   logic [TB-1:0]         best_key_ff, best_key_in, best_dl_ff, best_dl_in;
   logic [TB-1:0]         best_per_ff, best_per_in;
   logic [SW-1:0]         best_idx_ff, best_idx_in;
   logic                  best_rel_ff, best_rel_in, best_fn_ff, best_fn_in;
   logic                  earliest_ff, earliest_in;
   logic [NUM_SLOTS-1:0]  running_ff, running_in, fired_ff, fired_in;
   logic [NW-1:0]         nfired_ff, nfired_in;
   logic                  pend_vld_ff, pend_vld_in;
   logic [SW-1:0]         pend_slot_ff, pend_slot_in;
   logic                  rsp_vld_ff, rsp_vld_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  wr_en;
   logic [SW-1:0]         wr_addr;
   logic [EW-1:0]         wr_data, rd_data;

   logic [TB-1:0]         now_t, per_t, rd_dl, rd_per, key_i, knew;
   logic [TB-1:0]         best_d, nd, ahd_d, rl_dl, start_dl;
   logic                  eligible, due, ahd;
   logic [SW-1:0]         slot, q_slot;
   logic [30:0]           rem;

   stem_ram #(.WIDTH(EW), .DEPTH(NUM_SLOTS)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      now_t = TB'(cmd_ff.req.now_time);
      per_t = TB'(cmd_ff.req.period);
      slot = SW'(cmd_ff.req.slot_id);
      q_slot = SW'(q_in.cmd.req.slot_id);
      rd_dl = rd_data[EW-1 -: TB];
      rd_per = rd_data[TB+1 -: TB];
      // Biasing the wrapped difference makes unsigned order equal signed order.
      key_i = (rd_dl - now_t) ^ TSIGN;
      knew = per_t ^ TSIGN;
      eligible = cmp_vld_ff && running_ff[cmp_idx_ff] && !fired_ff[cmp_idx_ff];
      best_d = best_key_ff ^ TSIGN;
      due = best_found_ff && !((best_d != '0) && !best_d[TB-1]);
      nd = best_dl_ff + best_per_ff;
      ahd_d = nd - now_t;
      ahd = (ahd_d != '0) && !ahd_d[TB-1];
      rl_dl = (!best_fn_ff && ahd) ? nd : now_t + best_per_ff;
      start_dl = now_t + per_t;
      if (!best_found_ff) begin
         rem = max_wait;
      end else if (best_d[TB-1]) begin
         rem = '0;
      end else if (CW'(best_d) > CW'(max_wait)) begin
         rem = max_wait;
      end else begin
         rem = 31'(best_d);
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_in.valid) begin
               case (q_in.cmd.cls)
                  CLS_START: begin
                     if (q_in.cmd.slot_ok && !running_ff[q_slot]) state_in = ST_SCAN;
                  end
                  CLS_RESTART: begin
                     if (q_in.cmd.slot_ok) state_in = ST_SCAN;
                  end
                  CLS_CHECK, CLS_QUERY: state_in = ST_SCAN;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCAN: begin
            if (idx_ff == LAST_IDX) state_in = ST_DRAIN;
         end
         ST_DRAIN: state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (cmd_ff.cls == CLS_CHECK && due) begin
               if (nfired_ff + NW'(1) == NW'(MAX_RESULTS)) state_in = ST_FLUSH;
               else state_in = ST_SCAN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_FLUSH: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      cmd_in = cmd_ff;
      idx_in = idx_ff;
      cmp_idx_in = idx_ff;
      cmp_vld_in = 1'b0;
      best_found_in = best_found_ff;
      best_key_in = best_key_ff;
      best_dl_in = best_dl_ff;
      best_per_in = best_per_ff;
      best_idx_in = best_idx_ff;
      best_rel_in = best_rel_ff;
      best_fn_in = best_fn_ff;
      earliest_in = earliest_ff;
      running_in = running_ff;
      fired_in = fired_ff;
      nfired_in = nfired_ff;
      pend_vld_in = pend_vld_ff;
      pend_slot_in = pend_slot_ff;
      rsp_vld_in = 1'b0;
      rsp_in = '0;
      pop = 1'b0;
      wr_en = 1'b0;
      wr_addr = slot;
      wr_data = {start_dl, per_t, cmd_ff.req.auto_reload, cmd_ff.req.reload_from_now};

      // Compare stage: one slot's stored entry arrives per cycle.
      if (eligible) begin
         if (cmd_ff.cls == CLS_START || cmd_ff.cls == CLS_RESTART) begin
            if (cmp_idx_ff != slot && key_i <= knew) earliest_in = 1'b0;
         end else if (!best_found_ff || key_i < best_key_ff) begin
            best_found_in = 1'b1;
            best_key_in = key_i;
            best_dl_in = rd_dl;
            best_per_in = rd_per;
            best_idx_in = cmp_idx_ff;
            best_rel_in = rd_data[1];
            best_fn_in = rd_data[0];
         end
      end

      case (state_ff)
         ST_IDLE: begin
            pop = q_in.valid;
            if (q_in.valid) begin
               cmd_in = q_in.cmd;
               idx_in = '0;
               best_found_in = 1'b0;
               earliest_in = 1'b1;
               fired_in = '0;
               nfired_in = '0;
               pend_vld_in = 1'b0;
               rsp_in.last = 1'b1;
               case (q_in.cmd.cls)
                  CLS_START: begin
                     if (!q_in.cmd.slot_ok) begin
                        rsp_vld_in = 1'b1;
                     end else if (running_ff[q_slot]) begin
                        rsp_vld_in = 1'b1;
                        rsp_in.status = STATUS_BUSY;
                     end
                  end
                  CLS_RESTART: begin
                     if (!q_in.cmd.slot_ok) rsp_vld_in = 1'b1;
                     else running_in[q_slot] = 1'b0;
                  end
                  CLS_STOP: begin
                     if (q_in.cmd.slot_ok) running_in[q_slot] = 1'b0;
                     rsp_vld_in = 1'b1;
                  end
                  CLS_CHECK, CLS_QUERY: rsp_vld_in = 1'b0;
                  default: rsp_vld_in = 1'b1;
               endcase
            end
         end
         ST_SCAN: begin
            cmp_vld_in = 1'b1;
            cmp_idx_in = idx_ff;
            idx_in = idx_ff + SW'(1);
         end
         ST_DRAIN: cmp_vld_in = 1'b0;
         ST_DECIDE: begin
            rsp_in.last = 1'b1;
            case (cmd_ff.cls)
               CLS_START, CLS_RESTART: begin
                  wr_en = 1'b1;
                  running_in[slot] = 1'b1;
                  rsp_vld_in = 1'b1;
                  rsp_in.status = earliest_ff ? STATUS_EARLIEST : STATUS_OK;
               end
               CLS_QUERY: begin
                  rsp_vld_in = 1'b1;
                  rsp_in.remaining = rem;
               end
               CLS_CHECK: begin
                  if (due) begin
                     // The previous firing is reported once it is known not to be last.
                     fired_in[best_idx_ff] = 1'b1;
                     running_in[best_idx_ff] = best_rel_ff;
                     wr_en = best_rel_ff;
                     wr_addr = best_idx_ff;
                     wr_data = {rl_dl, best_per_ff, best_rel_ff, best_fn_ff};
                     nfired_in = nfired_ff + NW'(1);
                     pend_vld_in = 1'b1;
                     pend_slot_in = best_idx_ff;
                     idx_in = '0;
                     best_found_in = 1'b0;
                     rsp_vld_in = pend_vld_ff;
                     rsp_in.expired_valid = 1'b1;
                     rsp_in.expired_slot = 4'(pend_slot_ff);
                     rsp_in.last = 1'b0;
                  end else begin
                     rsp_vld_in = 1'b1;
                     rsp_in.expired_valid = pend_vld_ff;
                     rsp_in.expired_slot = pend_vld_ff ? 4'(pend_slot_ff) : 4'd0;
                  end
               end
               default: rsp_vld_in = 1'b0;
            endcase
         end
         ST_FLUSH: begin
            rsp_vld_in = 1'b1;
            rsp_in.expired_valid = 1'b1;
            rsp_in.expired_slot = 4'(pend_slot_ff);
            rsp_in.last = 1'b1;
         end
         default: rsp_vld_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         running_ff <= '0;
         cmp_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         running_ff <= running_in;
         cmp_vld_ff <= cmp_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      idx_ff <= idx_in;
      cmp_idx_ff <= cmp_idx_in;
      best_found_ff <= best_found_in;
      best_key_ff <= best_key_in;
      best_dl_ff <= best_dl_in;
      best_per_ff <= best_per_in;
      best_idx_ff <= best_idx_in;
      best_rel_ff <= best_rel_in;
      best_fn_ff <= best_fn_in;
      earliest_ff <= earliest_in;
      fired_ff <= fired_in;
      nfired_ff <= nfired_in;
      pend_vld_ff <= pend_vld_in;
      pend_slot_ff <= pend_slot_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_item = rsp_ff;
endmodule

@@ hw/rtl/software_timer_expiry_manager.sv @@
// Stop and unknown commands answer in the cycle after the queue hands them over.
// A start of a valid idle slot, a restart of a valid slot and a query scan the slot RAM once, one slot a cycle.
// Check rescans the slot RAM after each firing until none is due; MAX_RESULTS firings end it with a flush.
// A two-entry command queue takes new transactions while the back end works; busy when full.
// Reset clears the running bits, the queue and sets max_wait to 60000; no clearing pass.
// Results are strobed for one cycle and cannot be stalled by the receiver.
`include "assert_macros.svh"
module software_timer_expiry_manager import stem_pkg::*; #(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF,
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  req_type     req_item,
   output logic        busy,
   output logic        rsp_valid,
   output rsp_type     rsp_item,
   input  logic        csr_we,
   input  logic [30:0] csr_wdata
);
   logic [30:0] max_wait_ff, max_wait_in;
   queue_type   q_bus;
   logic        pop;
   logic        fire_unclean;

   assign max_wait_in = csr_we ? csr_wdata : max_wait_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_wait_ff <= MAX_WAIT_RESET;
      end else begin
         max_wait_ff <= max_wait_in;
      end
   end

   stem_front #(.NUM_SLOTS(NUM_SLOTS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_item (req_item),
      .busy     (busy),
      .pop      (pop),
      .q_out    (q_bus)
   );

   stem_back #(.NUM_SLOTS(NUM_SLOTS), .TIME_BITS(TIME_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_in      (q_bus),
      .pop       (pop),
      .max_wait  (max_wait_ff),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   assign fire_unclean = rsp_valid && rsp_item.expired_valid &&
                         (rsp_item.status != STATUS_OK || rsp_item.remaining != 31'd0);

   `STEM_ASSERT(a_pop_has_item, clock, reset, pop |-> q_bus.valid)
   `STEM_ASSERT(a_busy_means_queued, clock, reset, busy |-> q_bus.valid)
   `STEM_ASSERT_NEVER(a_fire_fields_clean, clock, reset, fire_unclean)
endmodule
